// ----- hdl/ipv4fwd_pkg.sv -----
// Shared types, constants and helpers for the IPv4 forwarding decision block.
// Used by ipv4fwd_cmp and ipv4_forwarding_decision; depends on nothing.

package ipv4fwd_pkg;

	localparam int ROUTE_DEPTH = 64;
	localparam int ARP_DEPTH   = 64;
	localparam int PORT_COUNT  = 4;

	localparam int RT_AW  = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int NB_AW  = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
	localparam int MAX_DEPTH = (ROUTE_DEPTH > ARP_DEPTH) ? ROUTE_DEPTH : ARP_DEPTH;
	localparam int CNT_W  = $clog2(MAX_DEPTH + 1);

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 64;

	// Command codes carried on the input tuser.
	localparam logic [1:0] CMD_ROUTE    = 2'd0;
	localparam logic [1:0] CMD_ARP      = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;

	typedef enum logic [2:0] {
		ACT_FORWARD  = 3'd0,
		ACT_ARP_DROP = 3'd1,
		ACT_BAD_CSUM = 3'd2,
		ACT_TTL_EXC  = 3'd3,
		ACT_UNREACH  = 3'd4,
		ACT_ECHO     = 3'd5,
		ACT_ARP_MISS = 3'd6,
		ACT_WRITTEN  = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RSCAN,
		ST_RDEC,
		ST_ASCAN,
		ST_DONE
	} state_t;

	// Route table word; the prefix length is counted once, when the route is written.
	typedef struct packed {
		logic [5:0]  len;
		logic [1:0]  port;
		logic [31:0] mask;
		logic [31:0] prefix;
	} rt_word_t;

	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] ip;
	} nb_word_t;

	// Result of the shared match unit.
	typedef struct packed {
		logic hit;
		logic take;
	} cmp_res_t;

	function automatic logic [5:0] popcnt32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		a = v - ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		d = c + (c >> 8);
		e = d + (d >> 16);
		return e[5:0];
	endfunction

endpackage

// ----- hdl/ipv4_forwarding_decision.sv -----
// Top level of the IPv4 forwarding decision engine: sequencer, tables and output register.
// Depends on ipv4fwd_pkg, ipv4fwd_ram and ipv4fwd_cmp.
//
//   channel   dir  ports                           content
//   s_axis    in   s_tvalid s_tready s_tdata s_tuser  table write or header, cmd on tuser
//   m_axis    out  m_tvalid m_tready m_tdata m_tuser  decision, action on tuser
//   cfg       in   cfg_we cfg_index cfg_wdata          interface addresses 0..3
//
// Writes and early drops go straight from the idle state to the done state, which loads the output register.
// A classified header passes through the route scan and the route decision, then, when a route
// is found and no echo is due, the neighbor scan; the shared compare unit sees one entry a cycle.
// Reset clears the valid bits at once, so no clearing pass is needed.
// A word is accepted only in the idle state, which follows once the previous result is loaded;
// while the output register is full the sequencer waits in its last state.

module ipv4_forwarding_decision (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// entry_index, addr, prefix_mask, route_port, hw_addr, ttl_in, header_good,
	// arp_frame, echo_request, arrival_port, zero fill
	input  logic [ipv4fwd_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// egress_port, next_mac, ttl_out, matched_route
	output logic [ipv4fwd_pkg::OUT_DATA_W-1:0] m_tdata,
	// action
	output logic [2:0]                         m_tuser,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [31:0]                        cfg_wdata
);
	import ipv4fwd_pkg::*;

	// Input field split.
	logic [5:0]  in_entry_index;
	logic [31:0] in_addr;
	logic [31:0] in_prefix_mask;
	logic [1:0]  in_route_port;
	logic [47:0] in_hw_addr;
	logic [7:0]  in_ttl;
	logic        in_header_good;
	logic        in_arp_frame;
	logic        in_echo_request;
	logic [1:0]  in_arrival_port;

	assign in_entry_index  = s_tdata[5:0];
	assign in_addr         = s_tdata[37:6];
	assign in_prefix_mask  = s_tdata[69:38];
	assign in_route_port   = s_tdata[71:70];
	assign in_hw_addr      = s_tdata[119:72];
	assign in_ttl          = s_tdata[127:120];
	assign in_header_good  = s_tdata[128];
	assign in_arp_frame    = s_tdata[129];
	assign in_echo_request = s_tdata[130];
	assign in_arrival_port = s_tdata[132:131];

	logic [31:0] iface_q [4];

	state_t state_q, state_d;
	logic   accept;
	logic   out_load;

	logic [31:0]      addr_q;
	logic [7:0]       ttl_q;
	logic [1:0]       arr_q;
	logic             echo_hit_q;
	act_t             act_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_s1;
	logic             pend_s1;
	logic             found_q;
	logic [RT_AW-1:0] best_q;
	logic [5:0]       best_len_q;
	logic [1:0]       best_port_q;
	logic [47:0]      mac_q;

	logic [ROUTE_DEPTH-1:0] rt_valid_q;
	logic [ARP_DEPTH-1:0]   nb_valid_q;

	logic             m_tvalid_q;
	act_t             out_act_q;
	logic [1:0]       out_port_q;
	logic [47:0]      out_mac_q;
	logic [7:0]       out_ttl_q;
	logic [5:0]       out_route_q;

	// Table write on accept.
	logic     rt_we;
	logic     nb_we;
	rt_word_t rt_wword;
	nb_word_t nb_wword;
	rt_word_t rt_rword;
	nb_word_t nb_rword;

	assign accept = s_tvalid && s_tready;
	assign rt_we  = accept && (s_tuser == CMD_ROUTE) && (32'(in_entry_index) < ROUTE_DEPTH);
	assign nb_we  = accept && (s_tuser == CMD_ARP) && (32'(in_entry_index) < ARP_DEPTH);

	assign rt_wword.len    = popcnt32(in_prefix_mask);
	assign rt_wword.port   = in_route_port;
	assign rt_wword.mask   = in_prefix_mask;
	assign rt_wword.prefix = in_addr;
	assign nb_wword.mac    = in_hw_addr;
	assign nb_wword.ip     = in_addr;

	ipv4fwd_ram #(
		.WIDTH ($bits(rt_word_t)),
		.DEPTH (ROUTE_DEPTH)
	) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (RT_AW'(in_entry_index)),
		.wdata (rt_wword),
		.raddr (RT_AW'(cnt_q)),
		.rdata (rt_rword)
	);

	ipv4fwd_ram #(
		.WIDTH ($bits(nb_word_t)),
		.DEPTH (ARP_DEPTH)
	) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (NB_AW'(in_entry_index)),
		.wdata (nb_wword),
		.raddr (NB_AW'(cnt_q)),
		.rdata (nb_rword)
	);

	// The one compare unit serves the route scan and then the neighbor scan.
	logic        cmp_en;
	logic [31:0] cmp_ref;
	logic [31:0] cmp_mask;
	logic [5:0]  cmp_len;
	logic        cmp_found;
	cmp_res_t    cmp_res;

	always_comb begin
		if (state_q == ST_ASCAN) begin
			cmp_en    = pend_s1 && nb_valid_q[idx_s1[NB_AW-1:0]];
			cmp_ref   = nb_rword.ip;
			cmp_mask  = '1;
			cmp_len   = '0;
			cmp_found = 1'b0;
		end else begin
			cmp_en    = pend_s1 && rt_valid_q[idx_s1[RT_AW-1:0]];
			cmp_ref   = rt_rword.prefix;
			cmp_mask  = rt_rword.mask;
			cmp_len   = rt_rword.len;
			cmp_found = found_q;
		end
	end

	ipv4fwd_cmp u_cmp (
		.en       (cmp_en),
		.key      (addr_q),
		.ref_val  (cmp_ref),
		.mask     (cmp_mask),
		.len      (cmp_len),
		.best_len (best_len_q),
		.found    (cmp_found),
		.res      (cmp_res)
	);

	logic rt_last;
	logic nb_last;
	logic echo_hit;

	assign rt_last = pend_s1 && (idx_s1 == CNT_W'(ROUTE_DEPTH - 1));
	assign nb_last = pend_s1 && (idx_s1 == CNT_W'(ARP_DEPTH - 1));

	always_comb begin
		echo_hit = 1'b0;
		for (int i = 0; i < PORT_COUNT; i++) begin
			if (iface_q[i] == in_addr) begin
				echo_hit = 1'b1;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if ((s_tuser == CMD_CLASSIFY) && !in_arp_frame && in_header_good
						&& (in_ttl > 8'd1)) begin
						state_d = ST_RSCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_RSCAN: begin
				if (rt_last) begin
					state_d = ST_RDEC;
				end
			end
			ST_RDEC: begin
				if (!found_q || echo_hit_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ASCAN;
				end
			end
			ST_ASCAN: begin
				if (cmp_res.hit || nb_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q     <= in_addr;
				ttl_q      <= in_ttl;
				arr_q      <= in_arrival_port;
				echo_hit_q <= in_echo_request && echo_hit;
				cnt_q      <= '0;
				pend_s1    <= 1'b0;
				found_q    <= 1'b0;
				best_q     <= '0;
				best_len_q <= '0;
				best_port_q <= '0;
				mac_q      <= '0;
				if (s_tuser != CMD_CLASSIFY) begin
					act_q <= ACT_WRITTEN;
				end else if (in_arp_frame) begin
					act_q <= ACT_ARP_DROP;
				end else if (!in_header_good) begin
					act_q <= ACT_BAD_CSUM;
				end else begin
					act_q <= ACT_TTL_EXC;
				end
			end
			ST_RSCAN: begin
				if (cnt_q < CNT_W'(ROUTE_DEPTH)) begin
					cnt_q   <= cnt_q + 1'b1;
					idx_s1  <= cnt_q;
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				if (cmp_res.take) begin
					found_q     <= 1'b1;
					best_q      <= idx_s1[RT_AW-1:0];
					best_len_q  <= rt_rword.len;
					best_port_q <= rt_rword.port;
				end
			end
			ST_RDEC: begin
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
				if (!found_q) begin
					act_q <= ACT_UNREACH;
				end else if (echo_hit_q) begin
					act_q <= ACT_ECHO;
				end else begin
					act_q <= ACT_ARP_MISS;
				end
			end
			ST_ASCAN: begin
				if (cnt_q < CNT_W'(ARP_DEPTH)) begin
					cnt_q   <= cnt_q + 1'b1;
					idx_s1  <= cnt_q;
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				// The first hit is the lowest matching index.
				if (cmp_res.hit) begin
					act_q <= ACT_FORWARD;
					mac_q <= nb_rword.mac;
				end
			end
			default: begin
				pend_s1 <= 1'b0;
			end
		endcase
	end

	// Valid bits and interface address registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_valid_q <= '0;
			nb_valid_q <= '0;
			for (int i = 0; i < 4; i++) begin
				iface_q[i] <= '0;
			end
		end else begin
			if (rt_we) begin
				rt_valid_q[RT_AW'(in_entry_index)] <= 1'b1;
			end
			if (nb_we) begin
				nb_valid_q[NB_AW'(in_entry_index)] <= 1'b1;
			end
			if (cfg_we) begin
				iface_q[cfg_index] <= cfg_wdata;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_act_q   <= act_q;
			out_route_q <= 6'(best_q);
			if (act_q == ACT_FORWARD) begin
				out_port_q <= best_port_q;
				out_mac_q  <= mac_q;
				out_ttl_q  <= ttl_q - 8'd1;
			end else begin
				out_port_q <= arr_q;
				out_mac_q  <= '0;
				out_ttl_q  <= ttl_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {out_route_q, out_ttl_q, out_mac_q, out_port_q};

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while the previous one is still in work");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_FORWARD) |-> (m_tdata[57:50] != 8'd0))
		else $error("forwarded word with zero TTL");

	a_unreach_route: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_UNREACH) |-> (m_tdata[63:58] == 6'd0))
		else $error("unreachable word with a matched route");

	a_ascan_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASCAN) |-> found_q)
		else $error("neighbor scan without a route");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_tvalid_q && !m_tready |=> (state_q == ST_DONE))
		else $error("result dropped while the output register was full");
`endif

endmodule

// ----- hdl/ipv4fwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated for the route and neighbor tables.

module ipv4fwd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/ipv4fwd_cmp.sv -----
// Shared masked-compare unit used by both table scans, one entry per cycle.
// Depends on ipv4fwd_pkg for the result struct.

module ipv4fwd_cmp (
	input  logic                  en,
	input  logic [31:0]           key,
	input  logic [31:0]           ref_val,
	input  logic [31:0]           mask,
	input  logic [5:0]            len,
	input  logic [5:0]            best_len,
	input  logic                  found,
	output ipv4fwd_pkg::cmp_res_t res
);
	import ipv4fwd_pkg::*;

	logic hit;

	assign hit = en && ((key & mask) == ref_val);

	// Later entries of equal length replace the current best.
	assign res.hit  = hit;
	assign res.take = hit && (!found || (len >= best_len));

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for ipv4_forwarding_decision: table writes, drop checks,
// longest-prefix route choice, echo replies, neighbor lookups and random traffic.
// Depends on ipv4fwd_pkg and the ipv4_forwarding_decision RTL only.
`timescale 1ns / 100ps

module tb;
	import ipv4fwd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 150;
	localparam int PHASE_WORDS = 460;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_IFACE_ADDR_0 = 2'd0;

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  slot;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [1:0]  rport;
		logic [47:0] mac;
		logic [7:0]  ttl;
		logic        good;
		logic        arp;
		logic        echo;
		logic [1:0]  arrival;
	} fwd_req_t;

	typedef struct {
		act_t        action;
		logic [1:0]  egress;
		logic [47:0] mac;
		logic [7:0]  ttl;
		logic [5:0]  route;
	} fwd_decision_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [31:0]           cfg_wdata = '0;

	// Mirror of the block's tables and interface addresses.
	logic [31:0] route_prefix [ROUTE_DEPTH];
	logic [31:0] route_mask [ROUTE_DEPTH];
	logic [1:0]  route_if [ROUTE_DEPTH];
	bit          route_valid [ROUTE_DEPTH];
	logic [31:0] nbr_ip [ARP_DEPTH];
	logic [47:0] nbr_mac [ARP_DEPTH];
	bit          nbr_valid [ARP_DEPTH];
	logic [31:0] iface_ip [4] = '{default: '0};

	fwd_decision_t pending_decisions[$];
	int  fail_count = 0;
	int  cycle_count = 0;
	bit  steady_flow = 1'b0;

	ipv4_forwarding_decision uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady_flow || ($urandom_range(99) >= 15);
	end

	// Works out the decision for one word and applies any table write it carries.
	function automatic fwd_decision_t decide_forwarding(input fwd_req_t r);
		fwd_decision_t d;
		bit          found;
		bit          own;
		bit          hit;
		logic [5:0]  best;
		int          best_len;
		int          len;
		logic [47:0] hit_mac;
		d.action = ACT_WRITTEN;
		d.egress = r.arrival;
		d.mac = '0;
		d.ttl = r.ttl;
		d.route = '0;
		if (r.cmd != CMD_CLASSIFY) begin
			if (r.cmd == CMD_ROUTE) begin
				route_prefix[r.slot] = r.addr;
				route_mask[r.slot] = r.mask;
				route_if[r.slot] = r.rport;
				route_valid[r.slot] = 1'b1;
			end else if (r.cmd == CMD_ARP) begin
				nbr_ip[r.slot] = r.addr;
				nbr_mac[r.slot] = r.mac;
				nbr_valid[r.slot] = 1'b1;
			end
			return d;
		end
		if (r.arp) begin
			d.action = ACT_ARP_DROP;
			return d;
		end
		if (!r.good) begin
			d.action = ACT_BAD_CSUM;
			return d;
		end
		if (r.ttl <= 8'd1) begin
			d.action = ACT_TTL_EXC;
			return d;
		end
		found = 1'b0;
		best = '0;
		best_len = 0;
		for (int i = 0; i < ROUTE_DEPTH; i++) begin
			if (route_valid[i] && (r.addr & route_mask[i]) == route_prefix[i]) begin
				len = $countones(route_mask[i]);
				// Later entries win ties, so among equal-length matches the highest index is kept.
				if (!found || len >= best_len) begin
					found = 1'b1;
					best = i[5:0];
					best_len = len;
				end
			end
		end
		if (!found) begin
			d.action = ACT_UNREACH;
			return d;
		end
		d.route = best;
		own = 1'b0;
		if (r.echo)
			for (int k = 0; k < PORT_COUNT; k++)
				if (iface_ip[k] == r.addr)
					own = 1'b1;
		if (own) begin
			d.action = ACT_ECHO;
			return d;
		end
		hit = 1'b0;
		hit_mac = '0;
		for (int i = 0; i < ARP_DEPTH; i++) begin
			if (!hit && nbr_valid[i] && nbr_ip[i] == r.addr) begin
				hit = 1'b1;
				hit_mac = nbr_mac[i];
			end
		end
		if (hit) begin
			d.action = ACT_FORWARD;
			d.egress = route_if[best];
			d.mac = hit_mac;
			d.ttl = r.ttl - 8'd1;
		end else begin
			d.action = ACT_ARP_MISS;
		end
		return d;
	endfunction

	function automatic fwd_req_t blank_req(input logic [1:0] cmd);
		fwd_req_t r;
		r.cmd = cmd;
		r.slot = '0;
		r.addr = '0;
		r.mask = '0;
		r.rport = '0;
		r.mac = '0;
		r.ttl = '0;
		r.good = 1'b0;
		r.arp = 1'b0;
		r.echo = 1'b0;
		r.arrival = '0;
		return r;
	endfunction

	function automatic fwd_req_t route_req(input logic [5:0] slot, input logic [31:0] prefix,
			input logic [31:0] mask, input logic [1:0] port);
		fwd_req_t r;
		r = blank_req(CMD_ROUTE);
		r.slot = slot;
		r.addr = prefix;
		r.mask = mask;
		r.rport = port;
		return r;
	endfunction

	function automatic fwd_req_t nbr_req(input logic [5:0] slot, input logic [31:0] ip,
			input logic [47:0] mac);
		fwd_req_t r;
		r = blank_req(CMD_ARP);
		r.slot = slot;
		r.addr = ip;
		r.mac = mac;
		return r;
	endfunction

	function automatic fwd_req_t header_req(input logic [31:0] dest, input logic [7:0] ttl,
			input logic good, input logic arp, input logic echo, input logic [1:0] arrival);
		fwd_req_t r;
		r = blank_req(CMD_CLASSIFY);
		r.addr = dest;
		r.ttl = ttl;
		r.good = good;
		r.arp = arp;
		r.echo = echo;
		r.arrival = arrival;
		return r;
	endfunction

	// Addresses from a small 10.x block, so routes and neighbors collide often.
	function automatic logic [31:0] lab_addr();
		return {8'd10, 6'd0, 2'($urandom_range(3)), 6'd0, 2'($urandom_range(3)),
			4'd0, 4'($urandom_range(15))};
	endfunction

	function automatic fwd_req_t random_req();
		fwd_req_t r;
		int pick;
		int len;
		int slot;
		r.slot = 6'($urandom);
		r.addr = $urandom;
		r.mask = $urandom;
		r.rport = 2'($urandom);
		r.mac = {16'($urandom), 32'($urandom)};
		r.ttl = 8'($urandom);
		r.good = 1'($urandom);
		r.arp = 1'($urandom);
		r.echo = 1'($urandom);
		r.arrival = 2'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			r.cmd = CMD_ROUTE;
			len = ($urandom_range(3) == 0) ? $urandom_range(32) : $urandom_range(8, 32);
			r.mask = (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
			if ($urandom_range(19) == 0)
				r.mask = $urandom;
			if ($urandom_range(19) != 0)
				r.addr = lab_addr() & r.mask;
		end else if (pick < 30) begin
			r.cmd = CMD_ARP;
			if ($urandom_range(4) != 0)
				r.addr = lab_addr();
		end else if (pick < 32) begin
			r.cmd = CMD_UNUSED;
		end else begin
			r.cmd = CMD_CLASSIFY;
			pick = $urandom_range(9);
			slot = $urandom_range(ARP_DEPTH - 1);
			if (pick < 4)
				r.addr = nbr_valid[slot] ? nbr_ip[slot] : lab_addr();
			else if (pick < 7)
				r.addr = lab_addr();
			else if (pick == 7)
				r.addr = iface_ip[$urandom_range(3)];
			r.good = ($urandom_range(19) != 0);
			r.arp = ($urandom_range(19) == 0);
			r.echo = ($urandom_range(3) == 0);
			r.ttl = ($urandom_range(9) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(2, 255));
		end
		return r;
	endfunction

	task automatic send_word(input fwd_req_t r);
		int gap;
		gap = 0;
		if (!steady_flow && $urandom_range(99) < 15)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'd0, r.arrival, r.echo, r.arp, r.good, r.ttl, r.mac, r.rport,
			r.mask, r.addr, r.slot};
		s_tuser <= r.cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_decisions.push_back(decide_forwarding(r));
	endtask

	// Registers are written only with nothing in flight.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_iface_addrs(input logic [31:0] a0, input logic [31:0] a1,
			input logic [31:0] a2, input logic [31:0] a3);
		logic [31:0] vals [4];
		vals = '{a0, a1, a2, a3};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IFACE_ADDR_0 + k[1:0];
			cfg_wdata <= vals[k];
			@(posedge clk);
			iface_ip[k] = vals[k];
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		fwd_decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_decisions.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result word: act=%0d data=%h", m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = pending_decisions.pop_front();
				if (m_tuser !== want.action || m_tdata[1:0] !== want.egress ||
						m_tdata[49:2] !== want.mac || m_tdata[57:50] !== want.ttl ||
						m_tdata[63:58] !== want.route) begin
					if (fail_count < 10) begin
						$display("mismatch: expected act=%0d port=%0d mac=%h ttl=%0d route=%0d",
							want.action, want.egress, want.mac, want.ttl, want.route);
						$display("          got act=%0d port=%0d mac=%h ttl=%0d route=%0d",
							m_tuser, m_tdata[1:0], m_tdata[49:2], m_tdata[57:50],
							m_tdata[63:58]);
					end
					fail_count++;
				end
			end
		end
	end

	task automatic test_early_drops();
		send_word(header_req(32'h0808_0808, 8'd64, 1'b1, 1'b0, 1'b0, 2'd2));
		send_word(header_req(32'hFFFF_FFFF, 8'd0, 1'b0, 1'b1, 1'b1, 2'd1));
		send_word(header_req(32'h0A01_0203, 8'd0, 1'b0, 1'b0, 1'b0, 2'd3));
		send_word(header_req(32'h0A01_0203, 8'd0, 1'b1, 1'b0, 1'b0, 2'd0));
		send_word(header_req(32'h0A01_0203, 8'd1, 1'b1, 1'b0, 1'b1, 2'd1));
	endtask

	task automatic test_table_writes();
		fwd_req_t r;
		// The spare command must leave both tables untouched.
		r = blank_req(CMD_UNUSED);
		r.slot = 6'd63;
		r.addr = 32'hFFFF_FFFF;
		r.mask = 32'hFFFF_FFFF;
		r.rport = 2'd3;
		r.mac = 48'hFFFF_FFFF_FFFF;
		r.ttl = 8'd255;
		r.good = 1'b1;
		r.arp = 1'b1;
		r.echo = 1'b1;
		r.arrival = 2'd3;
		send_word(r);
		send_word(route_req(6'd0, 32'h0000_0000, 32'h0000_0000, 2'd1));
		send_word(route_req(6'd63, 32'h0A00_0000, 32'hFF00_0000, 2'd2));
		send_word(route_req(6'd10, 32'h0A01_0000, 32'hFFFF_0000, 2'd3));
		send_word(route_req(6'd20, 32'h0A01_0000, 32'hFFFF_0000, 2'd0));
		send_word(route_req(6'd5, 32'hC0A0_C000, 32'hF0F0_F0F0, 2'd1));
		send_word(nbr_req(6'd0, 32'h0A01_0203, 48'hFFFF_FFFF_FFFF));
		send_word(nbr_req(6'd1, 32'h0A01_0203, 48'h0000_0000_0001));
		send_word(nbr_req(6'd63, 32'h0808_0808, 48'h0123_4567_89AB));
	endtask

	task automatic test_route_choice();
		// Equal /16 routes at slots 10 and 20; slot 20 must win.
		send_word(header_req(32'h0A01_0203, 8'd255, 1'b1, 1'b0, 1'b0, 2'd0));
		send_word(header_req(32'h0A02_0304, 8'd2, 1'b1, 1'b0, 1'b0, 2'd3));
		send_word(header_req(32'h0808_0808, 8'd2, 1'b1, 1'b0, 1'b0, 2'd2));
		send_word(header_req(32'hC5A3_C708, 8'd100, 1'b1, 1'b0, 1'b0, 2'd1));
	endtask

	task automatic test_echo_reply();
		send_word(header_req(32'h0A00_0001, 8'd64, 1'b1, 1'b0, 1'b1, 2'd1));
		send_word(header_req(32'hFFFF_FFFF, 8'd64, 1'b1, 1'b0, 1'b1, 2'd2));
		send_word(header_req(32'h0000_0000, 8'd2, 1'b1, 1'b0, 1'b1, 2'd3));
		send_word(header_req(32'h0808_0808, 8'd64, 1'b1, 1'b0, 1'b1, 2'd0));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					set_iface_addrs(lab_addr(), lab_addr(), lab_addr(), lab_addr());
				end
				1: begin
					set_iface_addrs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
				end
				2: begin
					set_iface_addrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				end
				default: begin
					set_iface_addrs($urandom, lab_addr(), $urandom, lab_addr());
				end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// A long run without any idle cycle on either side.
				steady_flow = (phase == 2) && (n >= 100) && (n < 400);
				send_word(random_req());
			end
			steady_flow = 1'b0;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_iface_addrs(32'hC0A8_0001, 32'h0A00_0001, 32'hFFFF_FFFF, 32'h0000_0000);
		test_early_drops();
		test_table_writes();
		test_route_choice();
		test_echo_reply();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_decisions.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ipv4fwd_pkg.sv
hdl/ipv4fwd_ram.sv
hdl/ipv4fwd_cmp.sv
hdl/ipv4_forwarding_decision.sv
sim/tb.sv
